// File: hw/rtl/ttf_pkg.sv
`default_nettype none
package ttf_pkg;

  // Argument store geometry.
  localparam int MAX_ARGS  = 8;
  localparam int ARG_IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
  localparam int ARG_W     = 16;

  // Decimal conversion: a 16-bit word has at most five digits.
  localparam int NUM_DIGITS = 5;
  localparam int DIG_IDX_W  = 3;
  localparam int CNT_W      = 4;

  // Reciprocal of ten for 16-bit operands: q = (v * RECIP_TEN) >> RECIP_SHIFT.
  localparam logic [15:0] RECIP_TEN   = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  // Character codes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PAD_DIR = 8'h44;
  localparam logic [7:0] CH_DEC_DIR = 8'h64;
  localparam logic [7:0] CH_CHR_DIR = 8'h63;
  localparam logic [7:0] CH_TCK_DIR = 8'h74;
  localparam logic [7:0] CH_FLG_DIR = 8'h66;
  localparam logic [7:0] TICK_LEAD  = 8'h01;
  localparam logic [7:0] FLAG_LEAD  = 8'h02;
  localparam logic [7:0] TICK_BIAS  = 8'h02;
  localparam logic [7:0] FLAG_BIAS  = 8'h01;
  localparam logic [3:0] DIGIT_MASK = 4'hF;

  // Request kinds.
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_TEMPLATE = 1'b1;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_PCT   = 2'd1,
    MODE_WIDTH = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    OP_BYTES = 3'd0,
    OP_CHAR  = 3'd1,
    OP_TICK  = 3'd2,
    OP_FLAG  = 3'd3,
    OP_NUM   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CONV = 2'd1,
    ST_EMIT = 2'd2
  } emit_state_t;

  // One decoded job handed from the parser to the emitter.
  typedef struct packed {
    op_t        op;
    logic       two_bytes;
    logic [7:0] b0;
    logic       l0;
    logic [7:0] b1;
    logic       l1;
    logic [3:0] width;
    logic       term;
  } job_t;

  typedef struct packed {
    logic                 en;
    logic [ARG_IDX_W-1:0] addr;
    logic [ARG_W-1:0]     data;
  } mem_wr_t;

  typedef struct packed {
    logic                 en;
    logic [ARG_IDX_W-1:0] addr;
  } mem_rd_t;

endpackage
`default_nettype wire

// File: hw/rtl/ttf_if.sv
`default_nettype none
interface ttf_in_if;
  import ttf_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [ARG_W-1:0] arg_value;
  logic [7:0]       template_byte;

  modport source (output valid, req_type, arg_value, template_byte, input ready);
  modport sink   (input valid, req_type, arg_value, template_byte, output ready);
endinterface

interface ttf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ttf_arg_store.sv
`default_nettype none
module ttf_arg_store (
  input  wire logic                    clk,
  input  wire ttf_pkg::mem_wr_t        wr,
  input  wire ttf_pkg::mem_rd_t        rd,
  output logic [ttf_pkg::ARG_W-1:0]    rdata
);
  import ttf_pkg::*;

  logic [ARG_W-1:0] mem [MAX_ARGS];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ttf_parser.sv
`default_nettype none
module ttf_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  ttf_in_if.sink                request,
  input  wire logic             job_take,
  output logic                  job_valid,
  output ttf_pkg::job_t         job,
  output ttf_pkg::mem_wr_t      mem_wr,
  output ttf_pkg::mem_rd_t      mem_rd
);
  import ttf_pkg::*;

  logic [ARG_IDX_W-1:0] load_index;
  logic [ARG_IDX_W-1:0] use_index;
  mode_t                parse_mode;

  logic                 accept;
  logic                 is_tmpl;
  job_t                 dec_job;
  logic                 dec_out;
  logic                 dec_arg;
  logic                 dec_clear;
  mode_t                mode_next;
  logic [7:0]           b;
  logic [ARG_IDX_W-1:0] load_index_inc;
  logic [ARG_IDX_W-1:0] use_index_inc;

  assign request.ready = !job_valid || job_take;
  assign accept        = request.valid && request.ready;
  assign is_tmpl       = (request.req_type == REQ_TEMPLATE);
  assign b             = request.template_byte;

  assign load_index_inc = (load_index == ARG_IDX_W'(MAX_ARGS - 1)) ? '0 : load_index + 1'b1;
  assign use_index_inc  = (use_index == ARG_IDX_W'(MAX_ARGS - 1)) ? '0 : use_index + 1'b1;

  // Decode one template byte against the current parse mode.
  always_comb begin
    dec_job           = '0;
    dec_job.op        = OP_BYTES;
    dec_out           = 1'b0;
    dec_arg           = 1'b0;
    dec_clear         = 1'b0;
    mode_next         = MODE_PLAIN;
    unique case (parse_mode)
      MODE_PCT: begin
        unique case (b)
          CH_PAD_DIR: begin
            mode_next = MODE_WIDTH;
          end
          CH_DEC_DIR: begin
            dec_out    = 1'b1;
            dec_arg    = 1'b1;
            dec_job.op = OP_NUM;
          end
          CH_CHR_DIR: begin
            dec_out    = 1'b1;
            dec_arg    = 1'b1;
            dec_job.op = OP_CHAR;
          end
          CH_TCK_DIR: begin
            dec_out    = 1'b1;
            dec_arg    = 1'b1;
            dec_job.op = OP_TICK;
          end
          CH_FLG_DIR: begin
            dec_out    = 1'b1;
            dec_arg    = 1'b1;
            dec_job.op = OP_FLAG;
          end
          CH_PCT: begin
            dec_out    = 1'b1;
            dec_job.b0 = CH_PCT;
          end
          default: begin
            // Unknown directive: a literal percent, then the byte as plain text.
            dec_job.b0 = CH_PCT;
            if (b == CH_NUL) begin
              dec_out           = 1'b1;
              dec_clear         = 1'b1;
              dec_job.two_bytes = 1'b1;
              dec_job.b1        = CH_NUL;
              dec_job.l1        = 1'b1;
            end else if (b == CH_PCT) begin
              dec_out   = 1'b1;
              mode_next = MODE_PCT;
            end else begin
              dec_out           = 1'b1;
              dec_job.two_bytes = 1'b1;
              dec_job.b1        = b;
            end
          end
        endcase
      end
      MODE_WIDTH: begin
        dec_out    = 1'b1;
        dec_arg    = 1'b1;
        dec_job.op = OP_NUM;
        if (b >= CH_ZERO && b <= CH_NINE) begin
          dec_job.width = (b[3:0] - CH_ZERO[3:0]) & DIGIT_MASK;
        end else if (b == CH_NUL) begin
          dec_job.term = 1'b1;
          dec_clear    = 1'b1;
        end
      end
      default: begin
        if (b == CH_NUL) begin
          dec_out    = 1'b1;
          dec_clear  = 1'b1;
          dec_job.b0 = CH_NUL;
          dec_job.l0 = 1'b1;
        end else if (b == CH_PCT) begin
          mode_next = MODE_PCT;
        end else begin
          dec_out    = 1'b1;
          dec_job.b0 = b;
        end
      end
    endcase
  end

  // Argument store ports: loads write, directives read at the use index.
  always_comb begin
    mem_wr.en   = accept && !is_tmpl;
    mem_wr.addr = load_index;
    mem_wr.data = request.arg_value;
    mem_rd.en   = accept && is_tmpl && dec_arg;
    mem_rd.addr = use_index;
  end

  // Parse state and argument indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      use_index  <= '0;
      parse_mode <= MODE_PLAIN;
    end else if (accept) begin
      if (!is_tmpl) begin
        load_index <= load_index_inc;
      end else begin
        parse_mode <= mode_next;
        if (dec_clear) begin
          load_index <= '0;
          use_index  <= '0;
        end else if (dec_arg) begin
          use_index <= use_index_inc;
        end
      end
    end
  end

  // Front register holding the next job for the emitter.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept && is_tmpl && dec_out) begin
      job_valid <= 1'b1;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_tmpl && dec_out) begin
      job <= dec_job;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ttf_emitter.sv
`default_nettype none
module ttf_emitter (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    job_valid,
  input  wire ttf_pkg::job_t           job,
  input  wire logic [ttf_pkg::ARG_W-1:0] arg_data,
  output logic                         job_take,
  ttf_out_if.source                    text
);
  import ttf_pkg::*;

  emit_state_t          state;
  emit_state_t          state_next;

  logic                 is_num;
  logic [7:0]           b0;
  logic                 l0;
  logic [7:0]           b1;
  logic                 l1;
  logic [3:0]           width;
  logic                 term;
  logic [ARG_W-1:0]     val;
  logic [3:0]           digs [NUM_DIGITS];
  logic [DIG_IDX_W-1:0] len;
  logic [CNT_W-1:0]     pads;
  logic [CNT_W-1:0]     total;
  logic [CNT_W-1:0]     cnt;

  logic                 out_load;
  logic                 cnt_last;
  logic                 conv_done;
  logic [31:0]          prod;
  logic [ARG_W-1:0]     quot;
  logic [ARG_W-1:0]     quot_x10;
  logic [3:0]           rem;
  logic [CNT_W-1:0]     len_p1;
  logic [CNT_W-1:0]     pads_new;
  logic [CNT_W-1:0]     digit_end;
  logic [CNT_W-1:0]     digit_pos;
  logic [7:0]           sel_byte;
  logic                 sel_last;
  logic [7:0]           arg_low;

  assign out_load = !text.valid || text.ready;
  assign cnt_last = (cnt == total - 1'b1);
  assign arg_low  = arg_data[7:0];

  // One decimal digit per cycle by multiplying with the reciprocal of ten.
  assign prod      = 32'(val) * 32'(RECIP_TEN);
  assign quot      = ARG_W'(prod[31:RECIP_SHIFT]);
  assign quot_x10  = (quot << 3) + (quot << 1);
  assign rem       = 4'(val - quot_x10);
  assign len_p1    = CNT_W'(len) + 1'b1;
  assign conv_done = (quot == '0) || (len_p1 == CNT_W'(NUM_DIGITS));
  assign pads_new  = (width > len_p1) ? width - len_p1 : '0;

  // Byte chosen for the current emit position.
  assign digit_end = pads + CNT_W'(len);
  assign digit_pos = digit_end - 1'b1 - cnt;
  always_comb begin
    sel_byte = b0;
    sel_last = l0;
    if (!is_num) begin
      if (cnt != '0) begin
        sel_byte = b1;
        sel_last = l1;
      end
    end else if (cnt < pads) begin
      sel_byte = CH_ZERO;
      sel_last = 1'b0;
    end else if (cnt < digit_end) begin
      sel_byte = CH_ZERO + 8'(digs[digit_pos[DIG_IDX_W-1:0]]);
      sel_last = 1'b0;
    end else begin
      sel_byte = CH_NUL;
      sel_last = 1'b1;
    end
  end

  // Sequencer: take a job, convert digits if needed, then emit its words.
  always_comb begin
    state_next = state;
    job_take   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        job_take = job_valid;
      end
      ST_CONV: begin
        if (conv_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && cnt_last) begin
          job_take   = job_valid;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (job_take) begin
      state_next = (job.op == OP_NUM) ? ST_CONV : ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Job datapath.
  always_ff @(posedge clk) begin
    if (job_take) begin
      is_num <= (job.op == OP_NUM);
      width  <= job.width;
      term   <= job.term;
      val    <= arg_data;
      len    <= '0;
      cnt    <= '0;
      l0     <= job.l0;
      l1     <= job.l1;
      case (job.op)
        OP_CHAR: begin
          b0    <= arg_low;
          b1    <= arg_low;
          total <= CNT_W'(1);
        end
        OP_TICK: begin
          b0    <= TICK_LEAD;
          b1    <= arg_low + TICK_BIAS;
          total <= CNT_W'(2);
        end
        OP_FLAG: begin
          b0    <= FLAG_LEAD;
          b1    <= arg_low + FLAG_BIAS;
          total <= CNT_W'(2);
        end
        default: begin
          b0    <= job.b0;
          b1    <= job.b1;
          total <= job.two_bytes ? CNT_W'(2) : CNT_W'(1);
        end
      endcase
    end else if (state == ST_CONV) begin
      digs[len] <= rem;
      len       <= len + 1'b1;
      val       <= quot;
      if (conv_done) begin
        pads  <= pads_new;
        total <= pads_new + len_p1 + CNT_W'(term);
      end
    end else if (state == ST_EMIT && out_load) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Output register toward the text channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      text.valid <= 1'b0;
    end else if (out_load) begin
      text.valid <= (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && state == ST_EMIT) begin
      text.out_byte <= sel_byte;
      text.last     <= sel_last;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/text_template_formatter_top.sv
`default_nettype none
// Template formatter. Argument words (req_type 0) are stored in an 8-entry
// argument memory; template bytes (req_type 1) are decoded at acceptance and
// queued as jobs for the emitter. A plain byte, %%, %c, and the terminator
// give one output word each; %t, %f and an unknown directive give two words.
// A numeric directive (%d, %Dn) reads its argument through the memory's
// registered read port, then converts one decimal digit per cycle with the
// reciprocal multiply (one to five digits), then emits one word per cycle
// while the receiver is ready, padding included. The input side keeps
// accepting while a job is emitted, one job deep. Stored arguments are not
// cleared by reset; reading a slot never loaded gives an undefined value.
module text_template_formatter_top (
  input  wire logic clk,
  input  wire logic rst,
  ttf_in_if.sink    request,
  ttf_out_if.source text
);
  import ttf_pkg::*;

  logic             job_valid;
  logic             job_take;
  job_t             job;
  mem_wr_t          mem_wr;
  mem_rd_t          mem_rd;
  logic [ARG_W-1:0] arg_data;

  ttf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .job_take  (job_take),
    .job_valid (job_valid),
    .job       (job),
    .mem_wr    (mem_wr),
    .mem_rd    (mem_rd)
  );

  ttf_arg_store u_store (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (arg_data)
  );

  ttf_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .arg_data  (arg_data),
    .job_take  (job_take),
    .text      (text)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ttf_pkg::*;

  // One word of expanded text as the block should deliver it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } text_word_t;

  // One directed stimulus row. Where typed is set, the row carries its own
  // expectation (zero or one word) instead of the one the predictor works out.
  typedef struct packed {
    logic        rq;
    logic [15:0] av;
    logic [7:0]  ch;
    logic        typed;
    logic        has_word;
    logic [7:0]  word_b;
    logic        word_l;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 29;
  localparam int TOTAL_WORDS   = DIRECTED_ROWS + 300;

  // Arguments go to slots 0..7 in order; the directives below use slots 0..6.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{REQ_LOAD,     16'd0,     CH_NUL,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_LOAD,     16'hFFFF,  CH_NUL,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_LOAD,     16'd5,     CH_NUL,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_LOAD,     16'd1234,  CH_NUL,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_LOAD,     16'h01FE,  CH_NUL,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_LOAD,     16'h00FF,  CH_NUL,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_LOAD,     16'd42,    CH_NUL,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_LOAD,     16'd100,   CH_NUL,     1'b1, 1'b0, CH_NUL,  1'b0},
    // Decimal of zero is a lone zero digit.
    '{REQ_TEMPLATE, 16'd0,     CH_PCT,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_DEC_DIR, 1'b1, 1'b1, CH_ZERO, 1'b0},
    // Largest value padded to nine digits.
    '{REQ_TEMPLATE, 16'd0,     CH_PCT,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_PAD_DIR, 1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_NINE,    1'b0, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_PCT,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_CHR_DIR, 1'b0, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_PCT,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_TCK_DIR, 1'b0, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_PCT,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_FLG_DIR, 1'b0, 1'b0, CH_NUL,  1'b0},
    // Escaped percent sign.
    '{REQ_TEMPLATE, 16'd0,     CH_PCT,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_PCT,     1'b1, 1'b1, CH_PCT,  1'b0},
    // Unknown directive: percent sign, then the byte as plain text.
    '{REQ_TEMPLATE, 16'd0,     CH_PCT,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     8'hFF,      1'b0, 1'b0, CH_NUL,  1'b0},
    // Width byte that is not a digit gives no padding.
    '{REQ_TEMPLATE, 16'd0,     CH_PCT,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_PAD_DIR, 1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     8'h7A,      1'b0, 1'b0, CH_NUL,  1'b0},
    // Zero width byte: unpadded value, then the terminator.
    '{REQ_TEMPLATE, 16'd0,     CH_PCT,     1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_PAD_DIR, 1'b1, 1'b0, CH_NUL,  1'b0},
    '{REQ_TEMPLATE, 16'd0,     CH_NUL,     1'b0, 1'b0, CH_NUL,  1'b0}
  };

  logic clk;
  logic rst;

  ttf_in_if  request ();
  ttf_out_if text ();

  text_template_formatter_top DUT (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .text    (text)
  );

  // Predictor state: argument slots, both indexes and the parse mode.
  logic [ARG_W-1:0]     arg_mem [MAX_ARGS];
  logic [ARG_IDX_W-1:0] load_ptr;
  logic [ARG_IDX_W-1:0] use_ptr;
  mode_t                parse_state;

  text_word_t fresh_words [$];
  text_word_t expected_text [$];

  int  words_sent;
  int  mismatches;
  bit  steady;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic void put_word(logic [7:0] b, logic l);
    text_word_t w;
    w.out_byte = b;
    w.last     = l;
    fresh_words.push_back(w);
  endfunction

  function automatic logic [ARG_W-1:0] next_arg();
    logic [ARG_W-1:0] v;
    v       = arg_mem[use_ptr];
    use_ptr = ARG_IDX_W'((int'(use_ptr) + 1) % MAX_ARGS);
    return v;
  endfunction

  // Unsigned decimal, zero padded to at least width digits.
  function automatic void put_number(logic [ARG_W-1:0] v, int width);
    logic [3:0]       digs [NUM_DIGITS];
    logic [ARG_W-1:0] rest;
    int               len;
    rest = v;
    len  = 0;
    do begin
      digs[len] = 4'(rest % 10);
      rest      = rest / 10;
      len++;
    end while (rest != 0 && len < NUM_DIGITS);
    for (int i = len; i < width; i++) put_word(CH_ZERO, 1'b0);
    while (len > 0) begin
      len--;
      put_word(CH_ZERO + 8'(digs[len]), 1'b0);
    end
  endfunction

  function automatic void plain_text(logic [7:0] ch);
    if (ch == CH_NUL) begin
      load_ptr    = '0;
      use_ptr     = '0;
      parse_state = MODE_PLAIN;
      put_word(CH_NUL, 1'b1);
    end else if (ch == CH_PCT) begin
      parse_state = MODE_PCT;
    end else begin
      put_word(ch, 1'b0);
    end
  endfunction

  // Expands one accepted word into fresh_words.
  function automatic void expand_word(logic rq, logic [ARG_W-1:0] av, logic [7:0] ch);
    logic [ARG_W-1:0] v;
    fresh_words.delete();
    if (rq == REQ_LOAD) begin
      arg_mem[load_ptr] = av;
      load_ptr          = ARG_IDX_W'((int'(load_ptr) + 1) % MAX_ARGS);
    end else begin
      case (parse_state)
        MODE_PCT: begin
          parse_state = MODE_PLAIN;
          case (ch)
            CH_PAD_DIR: parse_state = MODE_WIDTH;
            CH_DEC_DIR: put_number(next_arg(), 0);
            CH_CHR_DIR: begin
              v = next_arg();
              put_word(v[7:0], 1'b0);
            end
            CH_TCK_DIR: begin
              v = next_arg();
              put_word(TICK_LEAD, 1'b0);
              put_word(v[7:0] + TICK_BIAS, 1'b0);
            end
            CH_FLG_DIR: begin
              v = next_arg();
              put_word(FLAG_LEAD, 1'b0);
              put_word(v[7:0] + FLAG_BIAS, 1'b0);
            end
            CH_PCT: put_word(CH_PCT, 1'b0);
            default: begin
              put_word(CH_PCT, 1'b0);
              plain_text(ch);
            end
          endcase
        end
        MODE_WIDTH: begin
          parse_state = MODE_PLAIN;
          v = next_arg();
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            put_number(v, int'(4'(ch - CH_ZERO) & DIGIT_MASK));
          end else begin
            put_number(v, 0);
            if (ch == CH_NUL) plain_text(CH_NUL);
          end
        end
        default: begin
          parse_state = MODE_PLAIN;
          plain_text(ch);
        end
      endcase
    end
  endfunction

  // Offers one word, waits for the handshake, then records what it should produce.
  task automatic send_word(input logic rq, input logic [ARG_W-1:0] av, input logic [7:0] ch,
                           input bit typed = 1'b0, input bit has_word = 1'b0,
                           input text_word_t typed_word = '0);
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        request.valid <= 1'b0;
        @(posedge clk);
      end
    end
    request.valid         <= 1'b1;
    request.req_type      <= rq;
    request.arg_value     <= av;
    request.template_byte <= ch;
    do @(posedge clk); while (!request.ready);
    words_sent++;
    expand_word(rq, av, ch);
    if (typed) begin
      if (has_word) expected_text.push_back(typed_word);
    end else begin
      foreach (fresh_words[i]) expected_text.push_back(fresh_words[i]);
    end
  endtask

  // Receiver back-pressure.
  initial begin
    text.ready <= 1'b0;
    forever begin
      @(posedge clk);
      text.ready <= steady || ($urandom_range(99) >= 35);
    end
  end

  // Compare each delivered word with the oldest expectation.
  always @(posedge clk) begin
    text_word_t want;
    if (!rst && text.valid && text.ready) begin
      if (expected_text.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, actual byte %h last %b",
                 $realtime, text.out_byte, text.last);
      end else begin
        want = expected_text.pop_front();
        if (text.out_byte !== want.out_byte) begin
          mismatches++;
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $realtime, want.out_byte, text.out_byte);
        end
        if (text.last !== want.last) begin
          mismatches++;
          $display("%0t: last mismatch: expected %b, actual %b",
                   $realtime, want.last, text.last);
        end
      end
    end
  end

  initial begin
    logic [ARG_W-1:0] av;
    logic [7:0]       ch;
    int               pick;

    rst                   <= 1'b1;
    request.valid         <= 1'b0;
    request.req_type      <= REQ_LOAD;
    request.arg_value     <= '0;
    request.template_byte <= CH_NUL;
    steady      = 1'b0;
    words_sent  = 0;
    mismatches  = 0;
    load_ptr    = '0;
    use_ptr     = '0;
    parse_state = MODE_PLAIN;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; it writes every argument slot before any is read.
    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].rq, DIRECTED[i].av, DIRECTED[i].ch, DIRECTED[i].typed,
                DIRECTED[i].has_word, '{DIRECTED[i].word_b, DIRECTED[i].word_l});
    end

    // Random templates, mostly well formed, some noise in between.
    while (words_sent < TOTAL_WORDS) begin
      steady = (words_sent >= 130 && words_sent < 200);
      if ($urandom_range(99) < 80) begin
        repeat ($urandom_range(0, MAX_ARGS)) begin
          case ($urandom_range(3))
            0:       av = '0;
            1:       av = '1;
            2:       av = ARG_W'($urandom_range(0, 999));
            default: av = ARG_W'($urandom);
          endcase
          send_word(REQ_LOAD, av, 8'($urandom));
        end
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            do ch = 8'($urandom_range(1, 255)); while (ch == CH_PCT);
            send_word(REQ_TEMPLATE, ARG_W'($urandom), ch);
          end else begin
            send_word(REQ_TEMPLATE, ARG_W'($urandom), CH_PCT);
            case (pick)
              4:       ch = CH_DEC_DIR;
              5:       ch = CH_PAD_DIR;
              6:       ch = CH_CHR_DIR;
              7:       ch = CH_TCK_DIR;
              8:       ch = CH_FLG_DIR;
              default: ch = ($urandom_range(1) != 0) ? CH_PCT : 8'($urandom);
            endcase
            send_word(REQ_TEMPLATE, ARG_W'($urandom), ch);
            if (pick == 5) begin
              ch = ($urandom_range(99) < 80) ? CH_ZERO + 8'($urandom_range(0, 9))
                                             : 8'($urandom);
              send_word(REQ_TEMPLATE, ARG_W'($urandom), ch);
            end
          end
        end
        send_word(REQ_TEMPLATE, ARG_W'($urandom), CH_NUL);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(3))
            0:       ch = CH_PCT;
            1:       ch = CH_PAD_DIR;
            2:       ch = CH_NUL;
            default: ch = 8'($urandom);
          endcase
          send_word(1'($urandom), ARG_W'($urandom), ch);
        end
      end
    end
    steady = 1'b0;
    request.valid <= 1'b0;

    // Drain, then give the block time to show any stray word.
    while (expected_text.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: text_template_formatter_top.f
hw/rtl/ttf_pkg.sv
hw/rtl/ttf_if.sv
hw/rtl/ttf_arg_store.sv
hw/rtl/ttf_parser.sv
hw/rtl/ttf_emitter.sv
hw/rtl/text_template_formatter_top.sv
tb/testbench.sv
